// ----- rtl/core/psbl_pkg.sv -----
// Shared types and constants for the per-source ban and connection limit block.
// No dependencies.
`default_nettype none
package psbl_pkg;
    localparam int BAN_SLOTS_DEF  = 256;
    localparam int CONN_SLOTS_DEF = 256;

    localparam logic [15:0] MAX_CONN_RST  = 16'd20;
    localparam logic [7:0]  BAN_THR_RST   = 8'd5;
    localparam logic [30:0] BAN_TTL_RST   = 31'd300000;
    localparam logic [30:0] ENTRY_TTL_RST = 31'd120000;

    localparam logic [1:0] REG_MAX_CONN  = 2'd0;
    localparam logic [1:0] REG_BAN_THR   = 2'd1;
    localparam logic [1:0] REG_BAN_TTL   = 2'd2;
    localparam logic [1:0] REG_ENTRY_TTL = 2'd3;

    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_BANNED = 2'd1;
    localparam logic [1:0] VERDICT_LIMIT  = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_BAN_SWEEP,
        OP_CONN_SWEEP,
        OP_BAN_CLEAR,
        OP_BAN_SET,
        OP_CONN_UPDATE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] addr;
        logic [31:0] now;
        logic [31:0] value;
        logic [15:0] count;
        logic [7:0]  viol;
    } cmd_t;

    function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/psbl_ban_cell.sv -----
// One slot of the ban list: holds an address and expiry, matches and updates.
// Depends on psbl_pkg.
`default_nettype none
module psbl_ban_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire psbl_pkg::cmd_t   cmd,
    input  wire logic             sel_in,
    output logic                  valid,
    output logic                  match,
    output logic                  unexpired,
    output logic                  sel_out
);
    logic        valid_reg;
    logic [31:0] addr_reg;
    logic [31:0] expiry_reg;
    logic        take;

    assign valid     = valid_reg;
    assign match     = valid_reg && (addr_reg == cmd.addr);
    assign unexpired = psbl_pkg::is_before(cmd.now, expiry_reg);
    assign take      = sel_in && !valid_reg;
    assign sel_out   = sel_in && valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                psbl_pkg::OP_BAN_SWEEP:
                begin
                    if (valid_reg && psbl_pkg::is_before(expiry_reg, cmd.now))
                        valid_reg <= 1'b0;
                end
                psbl_pkg::OP_BAN_CLEAR:
                begin
                    if (match)
                        valid_reg <= 1'b0;
                end
                psbl_pkg::OP_BAN_SET:
                begin
                    if (take)
                        valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == psbl_pkg::OP_BAN_SET && (match || take))
        begin
            expiry_reg <= cmd.value;
            addr_reg   <= cmd.addr;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/psbl_conn_cell.sv -----
// One slot of the connection table: address, count, violations, last-seen time.
// Depends on psbl_pkg.
`default_nettype none
module psbl_conn_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire psbl_pkg::cmd_t   cmd,
    input  wire logic [30:0]      entry_ttl,
    input  wire logic             sel_in,
    output logic                  valid,
    output logic                  match,
    output logic [15:0]           count,
    output logic [7:0]            viol,
    output logic                  sel_out
);
    logic        valid_reg;
    logic [31:0] addr_reg;
    logic [15:0] count_reg;
    logic [7:0]  viol_reg;
    logic [31:0] seen_reg;
    logic        take;
    logic [31:0] idle_end;

    assign valid    = valid_reg;
    assign match    = valid_reg && (addr_reg == cmd.addr);
    assign count    = count_reg;
    assign viol     = viol_reg;
    assign take     = sel_in && !valid_reg;
    assign sel_out  = sel_in && valid_reg;
    assign idle_end = seen_reg + {1'b0, entry_ttl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                psbl_pkg::OP_CONN_SWEEP:
                begin
                    if (valid_reg && psbl_pkg::is_before(idle_end, cmd.now))
                        valid_reg <= 1'b0;
                end
                psbl_pkg::OP_CONN_UPDATE:
                begin
                    if (take)
                        valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == psbl_pkg::OP_CONN_UPDATE && (match || take))
        begin
            addr_reg  <= cmd.addr;
            seen_reg  <= cmd.now;
            count_reg <= cmd.count;
            viol_reg  <= cmd.viol;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/per_source_ban_and_conn_limit.sv -----
// Per-source ban and connection limit: top level with control sequencer. Depends on psbl_pkg.
// A result is given in S_OUT via S_BAN (banned source), S_SWEEP, S_BAN (sweep), S_BAN, S_CONN
// (packet) and S_BANSET (ban stored); the next transaction is accepted after it is taken.
// All slots act in parallel, so the rate does not depend on the store depth.
// Reset clears all valid bits and loads default register values.
`default_nettype none
module per_source_ban_and_conn_limit #(
    parameter int BAN_SLOTS  = psbl_pkg::BAN_SLOTS_DEF,
    parameter int CONN_SLOTS = psbl_pkg::CONN_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [31:0] src_ip,
    input  wire logic [31:0] now,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       verdict,
    output logic             ban_issued,
    output logic             untracked,
    output logic             ban_store_full,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    typedef enum logic [2:0] { S_IDLE, S_SWEEP, S_BAN, S_CONN, S_BANSET, S_OUT } state_t;

    state_t          state_reg;
    logic            req_reg;
    logic [31:0]     ip_reg;
    logic [31:0]     now_reg;
    logic [15:0]     max_conn_reg;
    logic [7:0]      ban_thr_reg;
    logic [30:0]     ban_ttl_reg;
    logic [30:0]     entry_ttl_reg;
    logic [1:0]      verdict_reg;
    logic            issued_reg;
    logic            untracked_reg;
    logic            bfull_reg;
    psbl_pkg::cmd_t  cmd;

    logic [BAN_SLOTS-1:0]  b_valid, b_match, b_unexp;
    logic [BAN_SLOTS:0]    b_sel;
    logic [CONN_SLOTS-1:0] c_valid, c_match;
    logic [CONN_SLOTS:0]   c_sel;
    logic [15:0]           c_count [CONN_SLOTS];
    logic [7:0]            c_viol  [CONN_SLOTS];

    logic        ban_hit, ban_live, conn_hit, conn_free, ban_free;
    logic [15:0] hit_count;
    logic [7:0]  hit_viol;
    logic [7:0]  viol_inc;
    logic        over, do_ban;

    // A free slot is only taken when no slot already holds the address.
    assign b_sel[0] = !ban_hit;
    assign c_sel[0] = !conn_hit;

    for (genvar i = 0; i < BAN_SLOTS; i++)
    begin : g_ban
        psbl_ban_cell u_cell (
            .clk(clk), .rst_n(rst_n), .cmd(cmd), .sel_in(b_sel[i]),
            .valid(b_valid[i]), .match(b_match[i]), .unexpired(b_unexp[i]),
            .sel_out(b_sel[i+1])
        );
    end

    for (genvar i = 0; i < CONN_SLOTS; i++)
    begin : g_conn
        psbl_conn_cell u_cell (
            .clk(clk), .rst_n(rst_n), .cmd(cmd), .entry_ttl(entry_ttl_reg),
            .sel_in(c_sel[i]), .valid(c_valid[i]), .match(c_match[i]),
            .count(c_count[i]), .viol(c_viol[i]), .sel_out(c_sel[i+1])
        );
    end

    always_comb
    begin
        ban_hit   = |b_match;
        ban_live  = |(b_match & b_unexp);
        conn_hit  = |c_match;
        conn_free = !(&c_valid);
        ban_free  = !(&b_valid);
        hit_count = '0;
        hit_viol  = '0;
        for (int i = 0; i < CONN_SLOTS; i++)
        begin
            if (c_match[i])
            begin
                hit_count = c_count[i];
                hit_viol  = c_viol[i];
            end
        end
        if (!conn_hit)
        begin
            hit_count = '0;
            hit_viol  = '0;
        end
        over     = hit_count >= max_conn_reg;
        viol_inc = (hit_viol == 8'hFF) ? hit_viol : hit_viol + 8'd1;
        do_ban   = over && (viol_inc >= ban_thr_reg);
    end

    always_comb
    begin
        cmd.op    = psbl_pkg::OP_NONE;
        cmd.addr  = ip_reg;
        cmd.now   = now_reg;
        cmd.value = now_reg + {1'b0, ban_ttl_reg};
        cmd.count = over ? hit_count : hit_count + 16'd1;
        cmd.viol  = over ? (do_ban ? 8'd0 : viol_inc) : hit_viol;
        unique case (state_reg)
            S_SWEEP: cmd.op = psbl_pkg::OP_BAN_SWEEP;
            S_BAN:   cmd.op = psbl_pkg::OP_BAN_CLEAR;
            S_CONN:  cmd.op = (conn_hit || conn_free) ? psbl_pkg::OP_CONN_UPDATE
                                                      : psbl_pkg::OP_NONE;
            S_BANSET: cmd.op = psbl_pkg::OP_BAN_SET;
            default: cmd.op = psbl_pkg::OP_NONE;
        endcase
        if (state_reg == S_SWEEP && req_reg)
            cmd.op = psbl_pkg::OP_BAN_SWEEP;
        if (state_reg == S_BAN && req_reg)
            cmd.op = psbl_pkg::OP_CONN_SWEEP;
        if (state_reg == S_BAN && !req_reg && ban_live)
            cmd.op = psbl_pkg::OP_NONE;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign cfg_ready      = (state_reg == S_IDLE);
    assign out_valid      = (state_reg == S_OUT);
    assign verdict        = verdict_reg;
    assign ban_issued     = issued_reg;
    assign untracked      = untracked_reg;
    assign ban_store_full = bfull_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_conn_reg  <= psbl_pkg::MAX_CONN_RST;
            ban_thr_reg   <= psbl_pkg::BAN_THR_RST;
            ban_ttl_reg   <= psbl_pkg::BAN_TTL_RST;
            entry_ttl_reg <= psbl_pkg::ENTRY_TTL_RST;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        unique case (cfg_index)
                            psbl_pkg::REG_MAX_CONN:  max_conn_reg  <= cfg_data[15:0];
                            psbl_pkg::REG_BAN_THR:   ban_thr_reg   <= cfg_data[7:0];
                            psbl_pkg::REG_BAN_TTL:   ban_ttl_reg   <= cfg_data[30:0];
                            psbl_pkg::REG_ENTRY_TTL: entry_ttl_reg <= cfg_data[30:0];
                        endcase
                    end
                    if (in_valid)
                    begin
                        req_reg       <= req_type;
                        ip_reg        <= src_ip;
                        now_reg       <= now;
                        verdict_reg   <= psbl_pkg::VERDICT_ACCEPT;
                        issued_reg    <= 1'b0;
                        untracked_reg <= 1'b0;
                        bfull_reg     <= 1'b0;
                        state_reg     <= req_type ? S_SWEEP : S_BAN;
                    end
                end
                S_SWEEP:
                    state_reg <= S_BAN;
                S_BAN:
                begin
                    if (req_reg)
                        state_reg <= S_OUT;
                    else if (ban_hit && ban_live)
                    begin
                        verdict_reg <= psbl_pkg::VERDICT_BANNED;
                        state_reg   <= S_OUT;
                    end
                    else
                        state_reg <= S_CONN;
                end
                S_CONN:
                begin
                    if (!conn_hit && !conn_free)
                    begin
                        untracked_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        if (over)
                            verdict_reg <= psbl_pkg::VERDICT_LIMIT;
                        if (do_ban)
                        begin
                            if (ban_hit || ban_free)
                                issued_reg <= 1'b1;
                            else
                                bfull_reg <= 1'b1;
                            state_reg <= (ban_hit || ban_free) ? S_BANSET : S_OUT;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_BANSET:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- dv/per_source_ban_and_conn_limit_test.sv -----
// Self-checking testbench for per_source_ban_and_conn_limit: directed table, store-filling
// phases and random traffic, checked by a behavioral predictor or fixed expected results.
// Depends on psbl_pkg and the per_source_ban_and_conn_limit RTL.
`timescale 1ns / 1ps
module per_source_ban_and_conn_limit_test;

    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_SWEEP  = 1'b1;
    localparam int   SLOTS      = 256;
    localparam int   CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0] verdict;
        logic       ban_issued;
        logic       untracked;
        logic       ban_store_full;
    } outcome_t;

    typedef struct {
        logic        req;
        logic [31:0] ip;
        logic [31:0] t;
        bit          typed;
        outcome_t    res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [31:0] src_ip = '0;
    logic [31:0] pkt_now = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  verdict;
    logic        ban_issued;
    logic        untracked;
    logic        ban_store_full;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [15:0] max_conn_r;
    logic [7:0]  ban_thr_r;
    logic [30:0] ban_ttl_r;
    logic [30:0] entry_ttl_r;
    bit          bl_valid [SLOTS];
    logic [31:0] bl_addr [SLOTS];
    logic [31:0] bl_expiry [SLOTS];
    bit          cn_valid [SLOTS];
    logic [31:0] cn_addr [SLOTS];
    logic [15:0] cn_count [SLOTS];
    logic [7:0]  cn_viol [SLOTS];
    logic [31:0] cn_seen [SLOTS];

    outcome_t    outcome_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          failed = 1'b0;
    int          cycles = 0;

    per_source_ban_and_conn_limit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .src_ip(src_ip), .now(pkt_now),
        .out_valid(out_valid), .out_stall(out_stall),
        .verdict(verdict), .ban_issued(ban_issued), .untracked(untracked),
        .ban_store_full(ban_store_full),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit earlier(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic bit record_ban(logic [31:0] ip, logic [31:0] t);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (bl_valid[i]) begin
                if (bl_addr[i] == ip) begin
                    bl_expiry[i] = t + {1'b0, ban_ttl_r};
                    return 1'b1;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (free_slot < 0) return 1'b0;
        bl_valid[free_slot] = 1'b1;
        bl_addr[free_slot] = ip;
        bl_expiry[free_slot] = t + {1'b0, ban_ttl_r};
        return 1'b1;
    endfunction

    function automatic outcome_t admit(logic req, logic [31:0] ip, logic [31:0] t);
        outcome_t r;
        int slot;
        int free_slot;
        r = '0;
        slot = -1;
        free_slot = -1;
        if (req == REQ_SWEEP) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (cn_valid[i] && earlier(cn_seen[i] + {1'b0, entry_ttl_r}, t))
                    cn_valid[i] = 1'b0;
                if (bl_valid[i] && earlier(bl_expiry[i], t))
                    bl_valid[i] = 1'b0;
            end
            return r;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (bl_valid[i] && bl_addr[i] == ip) begin
                if (earlier(t, bl_expiry[i])) begin
                    r.verdict = psbl_pkg::VERDICT_BANNED;
                    return r;
                end
                bl_valid[i] = 1'b0;
                break;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (cn_valid[i]) begin
                if (cn_addr[i] == ip) begin
                    slot = i;
                    break;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (slot < 0) begin
            if (free_slot < 0) begin
                r.untracked = 1'b1;
                return r;
            end
            slot = free_slot;
            cn_valid[slot] = 1'b1;
            cn_addr[slot] = ip;
            cn_count[slot] = '0;
            cn_viol[slot] = '0;
        end
        cn_seen[slot] = t;
        if (cn_count[slot] >= max_conn_r) begin
            if (cn_viol[slot] != 8'hFF) cn_viol[slot]++;
            if (cn_viol[slot] >= ban_thr_r) begin
                if (record_ban(ip, t)) r.ban_issued = 1'b1;
                else r.ban_store_full = 1'b1;
                cn_viol[slot] = '0;
            end
            r.verdict = psbl_pkg::VERDICT_LIMIT;
        end else begin
            cn_count[slot]++;
        end
        return r;
    endfunction

    task automatic send_item(logic req, logic [31:0] ip, logic [31:0] t,
                             bit typed = 1'b0, outcome_t res = '0);
        outcome_t predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        src_ip <= ip;
        pkt_now <= t;
        do @(posedge clk); while (in_stall);
        predicted = admit(req, ip, t);
        outcome_q.push_back(typed ? res : predicted);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            psbl_pkg::REG_MAX_CONN:  max_conn_r = data[15:0];
            psbl_pkg::REG_BAN_THR:   ban_thr_r = data[7:0];
            psbl_pkg::REG_BAN_TTL:   ban_ttl_r = data[30:0];
            psbl_pkg::REG_ENTRY_TTL: entry_ttl_r = data[30:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] mc, logic [7:0] thr, logic [30:0] bt, logic [30:0] et);
        write_reg(psbl_pkg::REG_MAX_CONN, {16'h0, mc});
        write_reg(psbl_pkg::REG_BAN_THR, {24'h0, thr});
        write_reg(psbl_pkg::REG_BAN_TTL, {1'b0, bt});
        write_reg(psbl_pkg::REG_ENTRY_TTL, {1'b0, et});
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected transaction on the result port");
                    failed = 1'b1;
                end else begin
                    outcome_t e;
                    e = outcome_q.pop_front();
                    if (verdict !== e.verdict) begin
                        $error("verdict: expected %0d, got %0d", e.verdict, verdict);
                        failed = 1'b1;
                    end
                    if (ban_issued !== e.ban_issued) begin
                        $error("ban_issued: expected %0d, got %0d", e.ban_issued, ban_issued);
                        failed = 1'b1;
                    end
                    if (untracked !== e.untracked) begin
                        $error("untracked: expected %0d, got %0d", e.untracked, untracked);
                        failed = 1'b1;
                    end
                    if (ban_store_full !== e.ban_store_full) begin
                        $error("ban_store_full: expected %0d, got %0d",
                               e.ban_store_full, ban_store_full);
                        failed = 1'b1;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        row_t        rows[$];
        logic [31:0] t;
        logic [31:0] pool[12];
        logic [15:0] tag;
        int          pick;

        max_conn_r = psbl_pkg::MAX_CONN_RST;
        ban_thr_r = psbl_pkg::BAN_THR_RST;
        ban_ttl_r = psbl_pkg::BAN_TTL_RST;
        entry_ttl_r = psbl_pkg::ENTRY_TTL_RST;
        for (int i = 0; i < SLOTS; i++) begin
            bl_valid[i] = 1'b0;
            cn_valid[i] = 1'b0;
        end

        rows = '{
            '{REQ_PACKET, 32'h0000_0000, 32'h0000_0000, 1'b1, '0},
            '{REQ_PACKET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0},
            '{REQ_SWEEP,  32'h0000_0000, 32'h0000_0000, 1'b1, '0},
            '{REQ_PACKET, 32'h5555_5555, 32'h7FFF_FFFF, 1'b1, '0},
            '{REQ_PACKET, 32'hAAAA_AAAA, 32'h8000_0000, 1'b1, '0},
            '{REQ_PACKET, 32'h0000_0000, 32'h0000_0001, 1'b0, '0},
            '{REQ_SWEEP,  32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0},
            '{REQ_PACKET, 32'h0000_0000, 32'h8000_0001, 1'b0, '0},
            '{REQ_PACKET, 32'hFFFF_FFFF, 32'h8000_0002, 1'b0, '0},
            '{REQ_SWEEP,  32'h1234_5678, 32'hFFFF_FFFF, 1'b0, '0},
            '{REQ_PACKET, 32'h5555_5555, 32'h0000_0000, 1'b0, '0},
            '{REQ_PACKET, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].req, rows[i].ip, rows[i].t, rows[i].typed, rows[i].res);
        for (int i = 0; i < 22; i++)
            send_item(REQ_PACKET, 32'hC0A8_0001, 32'h100 + i);
        drain();

        // Fill the ban list, then the connection table, then clear both.
        set_idling(1);
        configure(16'd0, 8'd0, 31'h7FFF_FFFF, 31'd0);
        t = $urandom;
        tag = 16'($urandom);
        for (int i = 0; i < SLOTS; i++)
            send_item(REQ_PACKET, {8'h0A, tag, i[7:0]}, t);
        send_item(REQ_PACKET, {8'h0A, tag, 8'h07}, t);
        send_item(REQ_SWEEP, 32'h0, t + 1);
        send_item(REQ_PACKET, {8'h0B, tag, 8'h00}, t + 1);
        drain();
        set_idling(2);
        configure(16'hFFFF, 8'hFF, 31'h7FFF_FFFF, 31'd0);
        for (int i = 0; i < SLOTS + 4; i++)
            send_item(REQ_PACKET, {8'h0C, tag[11:0], i[11:0]}, t + 2);
        send_item(REQ_SWEEP, 32'h0, t + 32'h8000_0000);
        drain();

        for (int p = 0; p < 6; p++) begin
            set_idling(p);
            case (p)
                0: configure(16'd1, 8'd1, 31'd40, 31'd60);
                1: configure(16'd0, 8'd2, 31'd0, 31'd0);
                2: configure(16'hFFFF, 8'hFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
                3: configure(16'd2, 8'd0, 31'd100, 31'd30);
                default: configure(16'($urandom_range(0, 4)), 8'($urandom_range(0, 3)),
                                   31'($urandom_range(0, 200)), 31'($urandom_range(0, 300)));
            endcase
            foreach (pool[k]) pool[k] = $urandom;
            t = $urandom;
            for (int n = 0; n < 110; n++) begin
                if (p == 3 && n == 55) begin
                    in_valid <= 1'b0;
                    while (outcome_q.size() != 0) @(posedge clk);
                end
                if ($urandom_range(99) < 5) t = t + $urandom;
                else t = t + $urandom_range(0, 20);
                pick = $urandom_range(99);
                if (pick < 8)
                    send_item(REQ_SWEEP, $urandom, t);
                else if (pick < 18)
                    send_item(REQ_PACKET, $urandom, t);
                else
                    send_item(REQ_PACKET, pool[$urandom_range(0, 11)], t);
            end
            drain();
        end

        if (!failed && outcome_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
